/* rtl/core/work_stealing_deque_bank_macros.svh */
`ifndef WORK_STEALING_DEQUE_BANK_MACROS_SVH
`define WORK_STEALING_DEQUE_BANK_MACROS_SVH

// same-cycle implication, checked out of reset
`define WSDB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WSDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wsdb_pkg.sv */
`timescale 1ns / 1ps

package wsdb_pkg;

    localparam int DEQUE_DEPTH = 1024;
    localparam int NUM_WORKERS = 8;
    localparam int HANDLE_BITS = 32;

    localparam int PTR_W  = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
    localparam int WID_W  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int CNT_W  = $clog2(DEQUE_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_WORKERS * DEQUE_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    typedef logic [PTR_W-1:0]       ptr_t;
    typedef logic [WID_W-1:0]       worker_idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_DONE  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  worker;
        logic [31:0] task_in;
        logic [2:0]  victim_hint;
    } request_t;

    typedef struct packed {
        logic [31:0] task_out;
        logic        task_valid;
        logic        stolen;
        logic [2:0]  source_worker;
        logic        overflow;
        logic [15:0] outstanding;
        logic        all_done;
    } result_t;

    // worker index modulo the number of deques, by repeated subtraction
    function automatic worker_idx_t wrap_worker(input logic [2:0] raw);
        logic [7:0] v;
        v = 8'(raw);
        for (int i = 0; i < 7; i++)
        begin
            if (v >= 8'(NUM_WORKERS))
            begin
                v = v - 8'(NUM_WORKERS);
            end
        end
        return worker_idx_t'(v);
    endfunction

endpackage

/* rtl/core/wsdb_ram.sv */
`timescale 1ns / 1ps

module wsdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/work_stealing_deque_bank.sv */
`timescale 1ns / 1ps

// Bank of per-worker task deques with an outstanding-task counter. One command
// is taken per clock (busy never rises) and its result word appears on result
// with result_valid for exactly one cycle, in the cycle after acceptance; that
// delay comes from the registered read of the task store RAM, while the head,
// tail and fill registers settle the target deque in the accepting cycle. The
// receiver cannot stall, so a result word is lost if not taken on its strobe.
// The task store needs no clearing pass: entries are only read once written.
// Write active_workers via cfg_valid/cfg_ready only while idle; not enforced.

`include "work_stealing_deque_bank_macros.svh"

module work_stealing_deque_bank (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wsdb_pkg::request_t request,
    output logic               result_valid,
    output wsdb_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);

    wsdb_pkg::ptr_t  head_reg  [wsdb_pkg::NUM_WORKERS];
    wsdb_pkg::ptr_t  tail_reg  [wsdb_pkg::NUM_WORKERS];
    wsdb_pkg::cnt_t  count_reg [wsdb_pkg::NUM_WORKERS];
    logic [wsdb_pkg::NUM_WORKERS-1:0] nonempty_reg;
    logic [wsdb_pkg::NUM_WORKERS-1:0] full_reg;
    logic [15:0] pending_reg;
    logic [3:0]  active_reg;
    logic        result_valid_reg;
    logic        task_valid_reg;
    logic        stolen_reg;
    logic [2:0]  source_reg;
    logic        overflow_reg;

    logic                    accept;
    wsdb_pkg::worker_idx_t   w;
    wsdb_pkg::worker_idx_t   victim;
    wsdb_pkg::worker_idx_t   target;
    logic [3:0]              eff;
    logic [7:0]              w8;
    logic [7:0]              hint8;
    logic [7:0]              n8;
    logic                    push_ok;
    logic                    push_ovf;
    logic                    pop_tail;
    logic                    pop_head;
    wsdb_pkg::ptr_t          tail_next;
    wsdb_pkg::ptr_t          head_next;
    wsdb_pkg::ptr_t          ptr_sel;
    wsdb_pkg::cnt_t          count_next;
    logic [15:0]             pending_next;
    wsdb_pkg::addr_t         addr;
    wsdb_pkg::handle_t       rdata;

    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        w     = wsdb_pkg::wrap_worker(request.worker);
        eff   = active_reg;
        if (active_reg == 4'd0)
        begin
            eff = 4'd1;
        end
        else if (32'(active_reg) > wsdb_pkg::NUM_WORKERS)
        begin
            eff = 4'(wsdb_pkg::NUM_WORKERS);
        end
        w8    = 8'(w);
        hint8 = 8'(request.victim_hint);
        n8    = 8'(eff);

        if (hint8 < n8 && hint8 != w8)
        begin
            victim = wsdb_pkg::worker_idx_t'(request.victim_hint);
        end
        else if (w8 + 8'd1 < n8)
        begin
            victim = wsdb_pkg::worker_idx_t'(w8 + 8'd1);
        end
        else
        begin
            victim = '0;
        end

        push_ok      = 1'b0;
        push_ovf     = 1'b0;
        pop_tail     = 1'b0;
        pop_head     = 1'b0;
        target       = w;
        pending_next = pending_reg;

        unique case (request.cmd)
            wsdb_pkg::CMD_PUSH:
            begin
                if (full_reg[w])
                begin
                    push_ovf = 1'b1;
                end
                else
                begin
                    push_ok = 1'b1;
                    if (pending_reg != 16'hFFFF)
                    begin
                        pending_next = pending_reg + 16'd1;
                    end
                end
            end
            wsdb_pkg::CMD_FETCH:
            begin
                if (nonempty_reg[w])
                begin
                    pop_tail = 1'b1;
                end
                else if (n8 > 8'd1 && victim != w && nonempty_reg[victim])
                begin
                    pop_head = 1'b1;
                    target   = victim;
                end
            end
            wsdb_pkg::CMD_DONE:
            begin
                if (pending_reg != 16'd0)
                begin
                    pending_next = pending_reg - 16'd1;
                end
            end
            wsdb_pkg::CMD_CLEAR:
            begin
                pending_next = 16'd0;
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase

        // ring pointer moves for the chosen deque
        if (tail_reg[target] == wsdb_pkg::ptr_t'(wsdb_pkg::DEQUE_DEPTH - 1))
        begin
            tail_next = push_ok ? '0 : tail_reg[target] - wsdb_pkg::ptr_t'(1);
        end
        else if (tail_reg[target] == '0)
        begin
            tail_next = push_ok ? wsdb_pkg::ptr_t'(1)
                                : wsdb_pkg::ptr_t'(wsdb_pkg::DEQUE_DEPTH - 1);
        end
        else
        begin
            tail_next = push_ok ? tail_reg[target] + wsdb_pkg::ptr_t'(1)
                                : tail_reg[target] - wsdb_pkg::ptr_t'(1);
        end

        if (head_reg[target] == wsdb_pkg::ptr_t'(wsdb_pkg::DEQUE_DEPTH - 1))
        begin
            head_next = '0;
        end
        else
        begin
            head_next = head_reg[target] + wsdb_pkg::ptr_t'(1);
        end

        count_next = push_ok ? count_reg[target] + wsdb_pkg::cnt_t'(1)
                             : count_reg[target] - wsdb_pkg::cnt_t'(1);

        if (pop_head)
        begin
            ptr_sel = head_reg[target];
        end
        else if (pop_tail)
        begin
            ptr_sel = tail_next;
        end
        else
        begin
            ptr_sel = tail_reg[target];
        end

        addr = wsdb_pkg::addr_t'(target) * wsdb_pkg::addr_t'(wsdb_pkg::DEQUE_DEPTH)
             + wsdb_pkg::addr_t'(ptr_sel);
    end

    wsdb_ram #(
        .WIDTH (wsdb_pkg::HANDLE_BITS),
        .DEPTH (wsdb_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && push_ok),
        .waddr (addr),
        .wdata (wsdb_pkg::handle_t'(request.task_in)),
        .raddr (addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '{default: '0};
            tail_reg         <= '{default: '0};
            count_reg        <= '{default: '0};
            nonempty_reg     <= '0;
            full_reg         <= '0;
            pending_reg      <= 16'd0;
            active_reg       <= 4'd1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= accept;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
            if (accept)
            begin
                pending_reg <= pending_next;
                if (push_ok || pop_tail || pop_head)
                begin
                    count_reg[target]    <= count_next;
                    nonempty_reg[target] <= (count_next != '0);
                    full_reg[target]     <=
                        (count_next == wsdb_pkg::cnt_t'(wsdb_pkg::DEQUE_DEPTH));
                end
                if (push_ok || pop_tail)
                begin
                    tail_reg[target] <= tail_next;
                end
                if (pop_head)
                begin
                    head_reg[target] <= head_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            task_valid_reg <= pop_tail || pop_head;
            stolen_reg     <= pop_head;
            source_reg     <= (pop_tail || pop_head) ? 3'(target) : 3'd0;
            overflow_reg   <= push_ovf;
        end
    end

    always_comb
    begin
        result.task_out      = task_valid_reg ? 32'(rdata) : 32'd0;
        result.task_valid    = task_valid_reg;
        result.stolen        = stolen_reg;
        result.source_worker = source_reg;
        result.overflow      = overflow_reg;
        result.outstanding   = pending_reg;
        result.all_done      = (pending_reg == 16'd0);
    end

    assign result_valid = result_valid_reg;

    `WSDB_ASSERT_NEXT(a_one_result_per_word, accept, result_valid,
        "accepted word produced no result strobe")
    `WSDB_ASSERT_NEXT(a_own_tail_first,
        accept && request.cmd == wsdb_pkg::CMD_FETCH && nonempty_reg[w],
        result.task_valid && !result.stolen,
        "fetch skipped a non-empty own deque")
    `WSDB_ASSERT_NEXT(a_push_counts,
        accept && request.cmd == wsdb_pkg::CMD_PUSH && !full_reg[w] && pending_reg != 16'hFFFF,
        result.outstanding == $past(pending_reg) + 16'd1 && !result.overflow,
        "accepted push did not raise the outstanding count")
    `WSDB_ASSERT_NOW(a_full_not_empty, 1'b1, (full_reg & ~nonempty_reg) == '0,
        "deque marked full and empty at once")

endmodule

/* test/work_stealing_deque_bank_test.sv */
`timescale 1ns / 1ps

module work_stealing_deque_bank_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int COUNT_TOP      = 65535;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    wsdb_pkg::request_t  request;
    logic                result_valid;
    wsdb_pkg::result_t   result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [3:0]          cfg_data;

    // model of the deque bank
    wsdb_pkg::handle_t   deque_store [wsdb_pkg::NUM_WORKERS][wsdb_pkg::DEQUE_DEPTH];
    wsdb_pkg::ptr_t      head_idx    [wsdb_pkg::NUM_WORKERS];
    wsdb_pkg::ptr_t      tail_idx    [wsdb_pkg::NUM_WORKERS];
    wsdb_pkg::cnt_t      fill_level  [wsdb_pkg::NUM_WORKERS];
    logic [15:0]         pending_count;
    logic [3:0]          active_cfg;

    wsdb_pkg::result_t   expected_results [$];

    int          fail_count;
    int          items_sent;
    int          checked_count;
    int          steal_count;
    int          overflow_count;
    int          idle_cycles;
    bit          idle_on;

    work_stealing_deque_bank u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int effective_workers(input logic [3:0] raw);
        if (raw == 4'd0)
        begin
            return 1;
        end
        if (int'(raw) > wsdb_pkg::NUM_WORKERS)
        begin
            return wsdb_pkg::NUM_WORKERS;
        end
        return int'(raw);
    endfunction

    function automatic wsdb_pkg::result_t predict_outcome(input wsdb_pkg::request_t r);
        wsdb_pkg::result_t res;
        int      w;
        int      n;
        int      v;
        res = '0;
        w = int'(r.worker) % wsdb_pkg::NUM_WORKERS;
        case (r.cmd)
            wsdb_pkg::CMD_PUSH:
            begin
                if (int'(fill_level[w]) >= wsdb_pkg::DEQUE_DEPTH)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    deque_store[w][tail_idx[w]] = r.task_in;
                    if (int'(tail_idx[w]) == wsdb_pkg::DEQUE_DEPTH - 1)
                    begin
                        tail_idx[w] = '0;
                    end
                    else
                    begin
                        tail_idx[w] = tail_idx[w] + 1'b1;
                    end
                    fill_level[w] = fill_level[w] + 1'b1;
                    if (int'(pending_count) < COUNT_TOP)
                    begin
                        pending_count = pending_count + 1'b1;
                    end
                end
            end
            wsdb_pkg::CMD_FETCH:
            begin
                if (fill_level[w] != '0)
                begin
                    if (tail_idx[w] == '0)
                    begin
                        tail_idx[w] = wsdb_pkg::ptr_t'(wsdb_pkg::DEQUE_DEPTH - 1);
                    end
                    else
                    begin
                        tail_idx[w] = tail_idx[w] - 1'b1;
                    end
                    fill_level[w] = fill_level[w] - 1'b1;
                    res.task_out = deque_store[w][tail_idx[w]];
                    res.task_valid = 1'b1;
                    res.source_worker = 3'(w);
                end
                else
                begin
                    n = effective_workers(active_cfg);
                    if (n > 1)
                    begin
                        if (int'(r.victim_hint) < n && int'(r.victim_hint) != w)
                        begin
                            v = int'(r.victim_hint);
                        end
                        else
                        begin
                            v = (w + 1 < n) ? w + 1 : 0;
                        end
                        if (v != w && fill_level[v] != '0)
                        begin
                            res.task_out = deque_store[v][head_idx[v]];
                            if (int'(head_idx[v]) == wsdb_pkg::DEQUE_DEPTH - 1)
                            begin
                                head_idx[v] = '0;
                            end
                            else
                            begin
                                head_idx[v] = head_idx[v] + 1'b1;
                            end
                            fill_level[v] = fill_level[v] - 1'b1;
                            res.task_valid = 1'b1;
                            res.stolen = 1'b1;
                            res.source_worker = 3'(v);
                        end
                    end
                end
            end
            wsdb_pkg::CMD_DONE:
            begin
                if (pending_count != '0)
                begin
                    pending_count = pending_count - 1'b1;
                end
            end
            default:
            begin
                pending_count = '0;
            end
        endcase
        res.outstanding = pending_count;
        res.all_done = (pending_count == '0);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // scoreboard: compare each result word, then predict the word accepted now
    always @(posedge clk)
    begin
        wsdb_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("task_out", want.task_out, result.task_out);
                    check_field("task_valid", 32'(want.task_valid),
                                32'(result.task_valid));
                    check_field("stolen", 32'(want.stolen), 32'(result.stolen));
                    check_field("source_worker", 32'(want.source_worker),
                                32'(result.source_worker));
                    check_field("overflow", 32'(want.overflow), 32'(result.overflow));
                    check_field("outstanding", 32'(want.outstanding),
                                32'(result.outstanding));
                    check_field("all_done", 32'(want.all_done), 32'(result.all_done));
                    checked_count++;
                    if (want.stolen)
                    begin
                        steal_count++;
                    end
                    if (want.overflow)
                    begin
                        overflow_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_outcome(request));
            end
            if (cfg_valid && cfg_ready)
            begin
                active_cfg = cfg_data;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic send_word(input wsdb_pkg::cmd_t c, input logic [2:0] w,
                             input logic [31:0] t, input logic [2:0] h);
        wsdb_pkg::request_t r;
        r.cmd = c;
        r.worker = w;
        r.task_in = t;
        r.victim_hint = h;
        while (idle_on && $urandom_range(99) < 7)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        items_sent++;
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_workers(input logic [3:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_single_worker();
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd1);
        send_word(wsdb_pkg::CMD_PUSH, 3'd0, 32'hFFFF_FFFF, 3'd0);
        send_word(wsdb_pkg::CMD_PUSH, 3'd0, 32'h0000_0000, 3'd7);
        send_word(wsdb_pkg::CMD_PUSH, 3'd0, 32'h1234_5678, 3'd3);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd1);
        send_word(wsdb_pkg::CMD_FETCH, 3'd3, 32'hFFFF_FFFF, 3'd2);
        send_word(wsdb_pkg::CMD_PUSH, 3'd3, 32'hA5A5_5A5A, 3'd2);
        send_word(wsdb_pkg::CMD_FETCH, 3'd3, 32'h0, 3'd2);
        send_word(wsdb_pkg::CMD_DONE, 3'd7, 32'h0, 3'd7);
        send_word(wsdb_pkg::CMD_DONE, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_DONE, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_DONE, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_DONE, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_PUSH, 3'd7, 32'h8000_0001, 3'd7);
        send_word(wsdb_pkg::CMD_CLEAR, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd7, 32'h0, 3'd0);
        wait_drain();
    endtask

    task automatic test_stealing();
        write_workers(4'd4);
        send_word(wsdb_pkg::CMD_PUSH, 3'd1, 32'h1111_0001, 3'd0);
        send_word(wsdb_pkg::CMD_PUSH, 3'd1, 32'h1111_0002, 3'd0);
        send_word(wsdb_pkg::CMD_PUSH, 3'd1, 32'h1111_0003, 3'd0);
        send_word(wsdb_pkg::CMD_PUSH, 3'd2, 32'h2222_0001, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd1);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd7);
        send_word(wsdb_pkg::CMD_FETCH, 3'd3, 32'h0, 3'd2);
        send_word(wsdb_pkg::CMD_FETCH, 3'd3, 32'h0, 3'd3);
        send_word(wsdb_pkg::CMD_FETCH, 3'd6, 32'h0, 3'd5);
        send_word(wsdb_pkg::CMD_PUSH, 3'd0, 32'h0000_00AA, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd6, 32'h0, 3'd6);
        send_word(wsdb_pkg::CMD_PUSH, 3'd6, 32'h6666_0001, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd6);
        send_word(wsdb_pkg::CMD_FETCH, 3'd6, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_CLEAR, 3'd2, 32'h0, 3'd0);
        wait_drain();
    endtask

    task automatic test_register_range();
        write_workers(4'd0);
        send_word(wsdb_pkg::CMD_PUSH, 3'd1, 32'hBEEF_0001, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd1);
        write_workers(4'd15);
        send_word(wsdb_pkg::CMD_FETCH, 3'd0, 32'h0, 3'd1);
        write_workers(4'd8);
        send_word(wsdb_pkg::CMD_PUSH, 3'd7, 32'h7777_0007, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd6, 32'h0, 3'd6);
        send_word(wsdb_pkg::CMD_PUSH, 3'd0, 32'h0F0F_0F0F, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd7, 32'h0, 3'd7);
        write_workers(4'd9);
        send_word(wsdb_pkg::CMD_PUSH, 3'd7, 32'hF0F0_F0F0, 3'd0);
        send_word(wsdb_pkg::CMD_FETCH, 3'd3, 32'h0, 3'd7);
        send_word(wsdb_pkg::CMD_FETCH, 3'd3, 32'h0, 3'd7);
        send_word(wsdb_pkg::CMD_CLEAR, 3'd0, 32'h0, 3'd0);
        wait_drain();
    endtask

    // fill one deque past its depth, then pop across the tail wrap below zero
    task automatic test_full_deque();
        write_workers(4'd1);
        for (int i = 0; i <= wsdb_pkg::DEQUE_DEPTH; i++)
        begin
            send_word(wsdb_pkg::CMD_PUSH, 3'd5, $urandom, 3'($urandom_range(7)));
        end
        for (int i = 0; i < 3; i++)
        begin
            send_word(wsdb_pkg::CMD_FETCH, 3'd5, $urandom, 3'($urandom_range(7)));
        end
        send_word(wsdb_pkg::CMD_CLEAR, 3'd0, 32'h0, 3'd0);
        wait_drain();
    endtask

    task automatic test_count_floor();
        send_word(wsdb_pkg::CMD_CLEAR, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_DONE, 3'd0, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_PUSH, 3'd2, 32'hCAFE_0001, 3'd0);
        send_word(wsdb_pkg::CMD_PUSH, 3'd2, 32'hCAFE_0002, 3'd0);
        send_word(wsdb_pkg::CMD_DONE, 3'd2, 32'h0, 3'd0);
        send_word(wsdb_pkg::CMD_CLEAR, 3'd0, 32'h0, 3'd0);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count, input logic [3:0] workers,
                                       input bit quiet);
        int             n;
        int             pick;
        wsdb_pkg::cmd_t c;
        logic [2:0]     w;
        write_workers(workers);
        n = effective_workers(workers);
        idle_on = !quiet;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 44)
            begin
                c = wsdb_pkg::CMD_PUSH;
            end
            else if (pick < 86)
            begin
                c = wsdb_pkg::CMD_FETCH;
            end
            else if (pick < 97)
            begin
                c = wsdb_pkg::CMD_DONE;
            end
            else
            begin
                c = wsdb_pkg::CMD_CLEAR;
            end
            if ($urandom_range(99) < 85)
            begin
                w = 3'($urandom_range(n - 1));
            end
            else
            begin
                w = 3'($urandom_range(7));
            end
            send_word(c, w, $urandom, 3'($urandom_range(7)));
        end
        wait_drain();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        fail_count = 0;
        items_sent = 0;
        checked_count = 0;
        steal_count = 0;
        overflow_count = 0;
        idle_cycles = 0;
        idle_on = 1'b1;
        pending_count = '0;
        active_cfg = 4'd1;
        for (int i = 0; i < wsdb_pkg::NUM_WORKERS; i++)
        begin
            head_idx[i] = '0;
            tail_idx[i] = '0;
            fill_level[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_worker();
        test_stealing();
        test_register_range();
        test_full_deque();
        test_count_floor();
        test_random_traffic(60, 4'd8, 1'b0);
        test_random_traffic(60, 4'd3, 1'b0);
        test_random_traffic(40, 4'd1, 1'b0);
        test_random_traffic(80, 4'd8, 1'b1);
        test_random_traffic(40, 4'd2, 1'b0);
        test_random_traffic(40, 4'd15, 1'b0);
        test_random_traffic(30, 4'd0, 1'b0);
        test_random_traffic(60, 4'd5, 1'b0);

        wait_drain();
        repeat (5) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d result words never arrived", expected_results.size());
            fail_count++;
        end

        $display("ran %0d commands, %0d result words checked, %0d steals, %0d overflows",
                 items_sent, checked_count, steal_count, overflow_count);
        $display("worker settings 0..15, a full deque, tail wrap, count floor at zero");
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/wsdb_pkg.sv
rtl/core/wsdb_ram.sv
rtl/core/work_stealing_deque_bank.sv
test/work_stealing_deque_bank_test.sv
